// ===== hw/rtl/cprt_pkg.sv =====
`timescale 1ns / 1ps

package cprt_pkg;

	// Number of page frames, the widths that follow from it and the other field widths.
	localparam int FRAMES = 8;
	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(2 * FRAMES);
	localparam int PAGE_W = 20;
	localparam int TIME_W = 32;
	localparam int FIDX_W = 3;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [TIME_W-1:0] time_t;
	typedef logic [FIDX_W-1:0] fidx_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_SCAN   = 3'b100
	} state_t;

	// Low bits of a frame number as reported on the frame_index port.
	localparam int WIDE_W = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;

	function automatic fidx_t to_fidx(input idx_t idx);
		logic [WIDE_W-1:0] wide;
		wide = WIDE_W'(idx);
		return wide[FIDX_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/clock_page_replacement_timed.sv =====
`timescale 1ns / 1ps

// Timed clock page replacement over a small set of page frames.
// A reference transaction is taken at a rising edge where start is high and
// busy is low; page_number and ref_time are sampled there. The block then
// stays busy while it works. The cycle after the accept, all frames are
// compared with the page at once; a hit updates that frame and the result
// is presented on the next cycle. On a miss, one shared compare and
// saturating increment unit examines one frame per cycle at the clock hand,
// for at most two passes over the frames. The done strobe then follows the
// frame that qualifies, or the last frame examined when none does. A new
// reference can be started in the cycle done is high; the block takes no
// new reference while busy, before it is through with the last one.
// Every result is shown for exactly one cycle with done high; the receiver
// cannot stall and must take it then.
// Reset empties every frame, clears reference bits and times and puts the
// hand on frame zero; the stored page numbers are only read once written.
module clock_page_replacement_timed (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cprt_pkg::page_t  page_number,
	input  cprt_pkg::time_t  ref_time,
	output logic             done,
	output logic             hit,
	output cprt_pkg::fidx_t  frame_index,
	output logic             replaced,
	output logic             evicted_valid,
	output cprt_pkg::page_t  evicted_page,
	output cprt_pkg::time_t  evicted_time,
	output logic             no_victim
);
	import cprt_pkg::*;

	state_t state_q;
	page_t  page_q;
	time_t  now_q;
	idx_t   hand_q;
	cnt_t   count_q;

	page_t             frame_page_q [FRAMES];
	logic [FRAMES-1:0] frame_valid_q;
	logic [FRAMES-1:0] frame_ref_q;
	time_t             frame_time_q [FRAMES];

	logic              done_q;
	logic              hit_q;
	fidx_t             frame_index_q;
	logic              replaced_q;
	logic              evicted_valid_q;
	page_t             evicted_page_q;
	time_t             evicted_time_q;
	logic              no_victim_q;

	logic              accept;
	logic [FRAMES-1:0] match;
	logic              any_match;
	idx_t              match_idx;
	logic              victim_ok;
	time_t             hand_time;
	time_t             passed_time;
	idx_t              hand_next;
	logic              scan_last;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	// Parallel hit search; the lowest matching frame wins.
	always_comb begin
		match_idx = '0;
		for (int f = 0; f < FRAMES; f++) begin
			match[f] = frame_valid_q[f] && (frame_page_q[f] == page_q);
		end
		for (int f = FRAMES - 1; f >= 0; f--) begin
			if (match[f]) begin
				match_idx = IDX_W'(f);
			end
		end
	end
	assign any_match = |match;

	// Shared scan unit: the age test and the saturating increment at the hand.
	assign hand_time = frame_time_q[hand_q];
	assign victim_ok = !frame_ref_q[hand_q] && (hand_time < now_q);
	assign passed_time = (hand_time == '1) ? hand_time : hand_time + TIME_W'(1);
	assign hand_next = (hand_q == IDX_W'(FRAMES - 1)) ? '0 : hand_q + IDX_W'(1);
	assign scan_last = (count_q == CNT_W'(2 * FRAMES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hand_q <= '0;
			count_q <= '0;
			frame_valid_q <= '0;
			frame_ref_q <= '0;
			for (int f = 0; f < FRAMES; f++) begin
				frame_time_q[f] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					count_q <= '0;
					if (any_match) begin
						frame_ref_q[match_idx] <= 1'b1;
						frame_time_q[match_idx] <= now_q;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (victim_ok) begin
						frame_valid_q[hand_q] <= 1'b1;
						frame_ref_q[hand_q] <= 1'b1;
						frame_time_q[hand_q] <= now_q;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						frame_ref_q[hand_q] <= 1'b0;
						frame_time_q[hand_q] <= passed_time;
						hand_q <= hand_next;
						count_q <= count_q + CNT_W'(1);
						if (scan_last) begin
							done_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request capture, page store and result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page_number;
			now_q <= ref_time;
		end
		if (state_q == ST_LOOKUP) begin
			hit_q <= 1'b1;
			frame_index_q <= to_fidx(match_idx);
			replaced_q <= 1'b0;
			evicted_valid_q <= 1'b0;
			evicted_page_q <= '0;
			evicted_time_q <= '0;
			no_victim_q <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			hit_q <= 1'b0;
			if (victim_ok) begin
				frame_page_q[hand_q] <= page_q;
				frame_index_q <= to_fidx(hand_q);
				replaced_q <= 1'b1;
				evicted_valid_q <= frame_valid_q[hand_q];
				evicted_page_q <= frame_valid_q[hand_q] ? frame_page_q[hand_q] : '0;
				evicted_time_q <= hand_time;
				no_victim_q <= 1'b0;
			end else begin
				// On the last pass the hand is back where the scan began.
				frame_index_q <= to_fidx(hand_next);
				replaced_q <= 1'b0;
				evicted_valid_q <= 1'b0;
				evicted_page_q <= '0;
				evicted_time_q <= '0;
				no_victim_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign frame_index = frame_index_q;
	assign replaced = replaced_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page = evicted_page_q;
	assign evicted_time = evicted_time_q;
	assign no_victim = no_victim_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cprt_pkg::*;

	typedef struct packed {
		logic  hit;
		fidx_t fidx;
		logic  replaced;
		logic  ev_valid;
		page_t ev_page;
		time_t ev_time;
		logic  no_victim;
	} lookup_result_t;

	typedef struct {
		page_t          pg;
		time_t          tm;
		bit             typed;
		lookup_result_t want;
	} ref_row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	page_t page_number;
	time_t ref_time;
	logic  done;
	logic  hit;
	fidx_t frame_index;
	logic  replaced;
	logic  evicted_valid;
	page_t evicted_page;
	time_t evicted_time;
	logic  no_victim;

	// Shadow copy of the frame table and the clock hand.
	page_t pg_tag[FRAMES];
	bit    pg_live[FRAMES];
	bit    pg_used[FRAMES];
	time_t pg_stamp[FRAMES];
	int    hand_pos;

	lookup_result_t outcome_q[$];
	int             mismatches;

	clock_page_replacement_timed dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.page_number(page_number),
		.ref_time(ref_time),
		.done(done),
		.hit(hit),
		.frame_index(frame_index),
		.replaced(replaced),
		.evicted_valid(evicted_valid),
		.evicted_page(evicted_page),
		.evicted_time(evicted_time),
		.no_victim(no_victim)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Applies one page reference to the shadow table and returns the outcome.
	function automatic lookup_result_t resolve_reference(input page_t pg, input time_t now);
		lookup_result_t r;
		int h;
		r = '0;
		for (int f = 0; f < FRAMES; f++) begin
			if (pg_live[f] && pg_tag[f] == pg) begin
				pg_used[f] = 1'b1;
				pg_stamp[f] = now;
				r.hit = 1'b1;
				r.fidx = fidx_t'(f);
				return r;
			end
		end
		for (int n = 0; n < 2 * FRAMES; n++) begin
			h = hand_pos;
			if (!pg_used[h] && pg_stamp[h] < now) begin
				r.fidx = fidx_t'(h);
				r.replaced = 1'b1;
				r.ev_valid = pg_live[h];
				r.ev_page = pg_live[h] ? pg_tag[h] : '0;
				r.ev_time = pg_stamp[h];
				pg_tag[h] = pg;
				pg_live[h] = 1'b1;
				pg_used[h] = 1'b1;
				pg_stamp[h] = now;
				return r;
			end
			pg_used[h] = 1'b0;
			if (pg_stamp[h] != '1)
				pg_stamp[h] = pg_stamp[h] + 1'b1;
			hand_pos = (h + 1 < FRAMES) ? h + 1 : 0;
		end
		r.fidx = fidx_t'(hand_pos);
		r.no_victim = 1'b1;
		return r;
	endfunction

	// Presents one reference and holds it until the block takes it.
	task automatic send_reference(input page_t pg, input time_t tm, input bit typed,
			input lookup_result_t want);
		lookup_result_t model;
		@(negedge clk);
		start <= 1'b1;
		page_number <= pg;
		ref_time <= tm;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model = resolve_reference(pg, tm);
		outcome_q.push_back(typed ? want : model);
	endtask

	task automatic hold_start_low(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	always @(posedge clk) begin
		lookup_result_t got;
		lookup_result_t want;
		if (arst_n && done) begin
			got = '{hit, frame_index, replaced, evicted_valid, evicted_page,
				evicted_time, no_victim};
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: hit=%0d idx=%0d no_victim=%0d",
						hit, frame_index, no_victim);
			end else begin
				want = outcome_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp hit=%0d idx=%0d rep=%0d ev_v=%0d ev_pg=%h ev_t=%h nv=%0d",
							want.hit, want.fidx, want.replaced, want.ev_valid,
							want.ev_page, want.ev_time, want.no_victim);
						$display("          got hit=%0d idx=%0d rep=%0d ev_v=%0d ev_pg=%h ev_t=%h nv=%0d",
							got.hit, got.fidx, got.replaced, got.ev_valid,
							got.ev_page, got.ev_time, got.no_victim);
					end
				end
			end
		end
	end

	initial begin
		#3ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		ref_row_t script[$];
		page_t    pool[12];
		time_t    base;
		page_t    pg;
		time_t    tm;
		int       r;
		int       spin;

		arst_n = 1'b0;
		start = 1'b0;
		page_number = '0;
		ref_time = '0;
		mismatches = 0;
		hand_pos = 0;
		for (int f = 0; f < FRAMES; f++) begin
			pg_tag[f] = '0;
			pg_live[f] = 1'b0;
			pg_used[f] = 1'b0;
			pg_stamp[f] = '0;
		end
		for (int i = 0; i < 12; i++)
			pool[i] = page_t'($urandom_range(0, 20'hFFFFF));

		// A zero time after reset can never find a victim; the scan passes every
		// frame twice, so all times end at two and the hand returns to zero.
		script.push_back('{20'h00000, 32'd0, 1'b1,
			'{1'b0, 3'd0, 1'b0, 1'b0, 20'h0, 32'd0, 1'b1}});
		script.push_back('{20'h00005, 32'd100, 1'b1,
			'{1'b0, 3'd0, 1'b1, 1'b0, 20'h0, 32'd2, 1'b0}});
		script.push_back('{20'h00005, 32'd7, 1'b1,
			'{1'b1, 3'd0, 1'b0, 1'b0, 20'h0, 32'd0, 1'b0}});
		script.push_back('{20'hFFFFF, 32'hFFFF_FFFF, 1'b0, '0});
		for (int i = 1; i <= 6; i++)
			script.push_back('{page_t'(i), time_t'(200 + i), 1'b0, '0});
		script.push_back('{20'h80000, 32'd300, 1'b0, '0});
		script.push_back('{20'h7FFFF, 32'h8000_0000, 1'b0, '0});
		script.push_back('{20'h0AAAA, 32'hAAAA_AAAA, 1'b0, '0});
		script.push_back('{20'h55555, 32'h5555_5555, 1'b0, '0});
		script.push_back('{20'h00000, 32'd0, 1'b0, '0});
		script.push_back('{20'hFFFFF, 32'd0, 1'b0, '0});
		script.push_back('{20'h12345, 32'hFFFF_FFFF, 1'b0, '0});
		script.push_back('{20'h00001, 32'd1, 1'b0, '0});
		script.push_back('{20'h00003, 32'd5, 1'b0, '0});
		script.push_back('{20'h54321, 32'hFFFF_FFFE, 1'b0, '0});
		script.push_back('{20'h00002, 32'h7FFF_FFFF, 1'b0, '0});

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			send_reference(script[i].pg, script[i].tm, script[i].typed, script[i].want);
			if ($urandom_range(0, 99) < 22)
				hold_start_low($urandom_range(1, 4));
		end

		// Mostly a small working set under a rising clock, so hits, evictions of
		// live pages and fruitless scans all occur; odd times and pages mixed in.
		base = 32'd1000;
		for (int i = 0; i < 1030; i++) begin
			if (i == 300) begin
				@(negedge clk);
				start <= 1'b0;
				while (outcome_q.size() != 0)
					@(posedge clk);
			end
			base = base + time_t'($urandom_range(0, 40));
			r = $urandom_range(0, 99);
			pg = pool[$urandom_range(0, 11)];
			tm = base;
			if (r >= 70 && r < 80)
				pg = page_t'($urandom_range(0, 20'hFFFFF));
			else if (r < 85 && r >= 80)
				tm = base - time_t'($urandom_range(0, 60));
			else if (r < 90 && r >= 85)
				tm = time_t'($urandom());
			else if (r < 93 && r >= 90)
				tm = '0;
			else if (r < 95 && r >= 93)
				tm = '1;
			else if (r >= 95) begin
				pg = page_t'($urandom_range(0, 20'hFFFFF));
				tm = time_t'($urandom_range(0, base));
			end
			send_reference(pg, tm, 1'b0, '0);
			if ((i < 400 || i > 650) && $urandom_range(0, 99) < 22)
				hold_start_low($urandom_range(1, 4));
		end

		@(negedge clk);
		start <= 1'b0;
		spin = 0;
		while (outcome_q.size() != 0 && spin < 5000) begin
			@(posedge clk);
			spin++;
		end
		repeat (20) @(posedge clk);
		mismatches += outcome_q.size();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
